[hw/rtl/ccs_pkg.sv]
// Shared types and constants for the camera-to-screen cursor smoother.
package ccs_pkg;

  // Averaging window; the depth is a power of two.
  localparam int unsigned WIN_LOG2     = 4;
  localparam int unsigned WINDOW_DEPTH = 1 << WIN_LOG2;
  localparam int unsigned SLOT_W       = (WIN_LOG2 > 0) ? WIN_LOG2 : 1;

  localparam int unsigned CAM_W   = 12;
  localparam int unsigned SCR_W   = 13;
  localparam int unsigned GAIN_W  = 6;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned GEST_W  = 8;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned SUM_W   = COORD_W + WIN_LOG2;

  // Mapping arithmetic widths.
  localparam int unsigned DIFF_W = CAM_W + 2;           // 2*pos - cam
  localparam int unsigned CS_W   = CAM_W + SCR_W;       // cam * scr
  localparam int unsigned DS_W   = DIFF_W + SCR_W + 1;  // (2*pos - cam) * scr
  localparam int unsigned NUM_W  = 34;                  // full numerator, signed
  localparam int unsigned MAG_W  = NUM_W - 1;           // numerator magnitude
  localparam int unsigned DEN_W  = CAM_W + 1;           // 2 * cam
  localparam int unsigned CNT_W  = $clog2(MAG_W + 1);

  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CAM_W-1:0]  CAM_W_RST  = CAM_W'(640);
  localparam logic [CAM_W-1:0]  CAM_H_RST  = CAM_W'(480);
  localparam logic [SCR_W-1:0]  SCR_W_RST  = SCR_W'(1920);
  localparam logic [SCR_W-1:0]  SCR_H_RST  = SCR_W'(1080);
  localparam logic [GAIN_W-1:0] X_GAIN_RST = GAIN_W'(4);
  localparam logic [GAIN_W-1:0] Y_GAIN_RST = GAIN_W'(10);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_WIDTH  = 3'd0,
    REG_CAMERA_HEIGHT = 3'd1,
    REG_SCREEN_WIDTH  = 3'd2,
    REG_SCREEN_HEIGHT = 3'd3,
    REG_X_GAIN        = 3'd4,
    REG_Y_GAIN        = 3'd5
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_FIX,
    ST_UPD,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic mul3;
    logic sum;
    logic start;
    logic fix;
    logic upd;
    logic emit;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/ccs_div.sv]
// Restoring divider, one quotient bit per cycle, unsigned operands.
module ccs_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [ccs_pkg::MAG_W-1:0] dividend_i,
  input  logic [ccs_pkg::DEN_W-1:0] divisor_i,
  output logic                     busy_o,
  output logic [ccs_pkg::MAG_W-1:0] quotient_o
);
  import ccs_pkg::*;

  logic [MAG_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] div_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] diff;
  logic             fits;

  assign rem_sh = {rem_q, quo_q[MAG_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b0, div_q};
  assign fits   = ~diff[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(MAG_W);
    end else if (busy_q) begin
      cnt_q  <= cnt_q - CNT_W'(1);
      busy_q <= (cnt_q != CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      // Shift in the next dividend bit, keep the trial remainder if it fits.
      quo_q <= {quo_q[MAG_W-2:0], fits};
      rem_q <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/ccs_axis.sv]
// One axis: scaled mapping, saturation, history ring and running average.
module ccs_axis (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ccs_pkg::cmd_t               cmd_i,
  input  logic [ccs_pkg::POS_W-1:0]   pos_i,
  input  logic [ccs_pkg::CAM_W-1:0]   cam_i,
  input  logic [ccs_pkg::SCR_W-1:0]   scr_i,
  input  logic [ccs_pkg::GAIN_W-1:0]  gain_i,
  output logic                        div_busy_o,
  output logic [ccs_pkg::COORD_W-1:0] avg_o
);
  import ccs_pkg::*;

  logic [POS_W-1:0]          pos_q;
  logic signed [DIFF_W-1:0]  d_q;
  logic [CS_W-1:0]           cs_q;
  logic signed [DS_W-1:0]    ds_q;
  logic signed [NUM_W-1:0]   dsg_q;
  logic signed [NUM_W-1:0]   num_q;
  logic [NUM_W-1:0]          abs_w;
  logic [MAG_W-1:0]          quo;
  logic signed [COORD_W-1:0] m_q;
  logic signed [COORD_W-1:0] m_d;

  logic [COORD_W-1:0]        ring_mem [WINDOW_DEPTH];
  logic [WINDOW_DEPTH-1:0]   vld_q;
  logic [SLOT_W-1:0]         slot_q;
  logic signed [COORD_W-1:0] rd_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic signed [SUM_W-1:0]   sum_d;
  logic signed [SUM_W-1:0]   bias;
  logic signed [SUM_W-1:0]   sum_rnd;

  // Mapping pipeline, one step per command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pos_q <= pos_i;
    end
    if (cmd_i.mul1) begin
      d_q  <= $signed({1'b0, pos_q, 1'b0}) - $signed({2'b0, cam_i});
      cs_q <= {13'b0, cam_i} * {12'b0, scr_i};
    end
    if (cmd_i.mul2) begin
      ds_q <= $signed(DS_W'(d_q)) * $signed({15'b0, scr_i});
    end
    if (cmd_i.mul3) begin
      dsg_q <= $signed(NUM_W'(ds_q)) * $signed({28'b0, gain_i});
    end
    if (cmd_i.sum) begin
      num_q <= dsg_q + $signed({9'b0, cs_q});
    end
    if (cmd_i.fix) begin
      m_q <= m_d;
    end
  end

  assign abs_w = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);

  ccs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.start),
    .dividend_i (abs_w[MAG_W-1:0]),
    .divisor_i  ({cam_i, 1'b0}),
    .busy_o     (div_busy_o),
    .quotient_o (quo)
  );

  // Restore the sign and clamp to 16 bits; a zero-size camera maps to zero.
  always_comb begin
    if (cam_i == '0) begin
      m_d = '0;
    end else if (num_q[NUM_W-1]) begin
      if (quo > MAG_W'(32768)) begin
        m_d = 16'sh8000;
      end else begin
        m_d = $signed(COORD_W'(-quo));
      end
    end else begin
      if (quo > MAG_W'(32767)) begin
        m_d = 16'sh7fff;
      end else begin
        m_d = $signed(quo[COORD_W-1:0]);
      end
    end
  end

  // History ring: read the oldest slot while dividing, replace it at update.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rd_q <= vld_q[slot_q] ? $signed(ring_mem[slot_q]) : '0;
    end
    if (cmd_i.upd) begin
      ring_mem[slot_q] <= m_q;
    end
  end

  assign sum_d = sum_q - $signed(SUM_W'(rd_q)) + $signed(SUM_W'(m_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      slot_q <= '0;
      sum_q  <= '0;
    end else if (cmd_i.upd) begin
      vld_q[slot_q] <= 1'b1;
      sum_q         <= sum_d;
      slot_q        <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  // Divide the sum by the window depth, truncating toward zero.
  assign bias    = sum_q[SUM_W-1] ? $signed(SUM_W'(WINDOW_DEPTH - 1)) : '0;
  assign sum_rnd = sum_q + bias;
  assign avg_o   = sum_rnd[WIN_LOG2 +: COORD_W];

endmodule

[hw/rtl/ccs_dp.sv]
// Datapath: configuration registers, both axes, button flag and output register.
module ccs_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ccs_pkg::cmd_t                  cmd_i,
  output ccs_pkg::stat_t                 stat_o,
  input  logic                           cfg_we_i,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ccs_pkg::IN_DATA_W-1:0]  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [ccs_pkg::OUT_DATA_W-1:0] out_data_o
);
  import ccs_pkg::*;

  logic [CAM_W-1:0]   cam_w_q, cam_h_q;
  logic [SCR_W-1:0]   scr_w_q, scr_h_q;
  logic [GAIN_W-1:0]  x_gain_q, y_gain_q;
  logic               btn_q;
  logic               ovalid_q;
  logic [COORD_W-1:0] cx_q, cy_q, avg_x, avg_y;
  logic               obtn_q;
  logic               busy_x, busy_y;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_w_q  <= CAM_W_RST;
      cam_h_q  <= CAM_H_RST;
      scr_w_q  <= SCR_W_RST;
      scr_h_q  <= SCR_H_RST;
      x_gain_q <= X_GAIN_RST;
      y_gain_q <= Y_GAIN_RST;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_CAMERA_WIDTH:  cam_w_q  <= cfg_data_i[CAM_W-1:0];
        REG_CAMERA_HEIGHT: cam_h_q  <= cfg_data_i[CAM_W-1:0];
        REG_SCREEN_WIDTH:  scr_w_q  <= cfg_data_i[SCR_W-1:0];
        REG_SCREEN_HEIGHT: scr_h_q  <= cfg_data_i[SCR_W-1:0];
        REG_X_GAIN:        x_gain_q <= cfg_data_i[GAIN_W-1:0];
        REG_Y_GAIN:        y_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  ccs_axis u_axis_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .pos_i      (in_data_i[POS_W-1:0]),
    .cam_i      (cam_w_q),
    .scr_i      (scr_w_q),
    .gain_i     (x_gain_q),
    .div_busy_o (busy_x),
    .avg_o      (avg_x)
  );

  ccs_axis u_axis_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .pos_i      (in_data_i[2*POS_W-1:POS_W]),
    .cam_i      (cam_h_q),
    .scr_i      (scr_h_q),
    .gain_i     (y_gain_q),
    .div_busy_o (busy_y),
    .avg_o      (avg_y)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      btn_q <= (in_data_i[2*POS_W +: GEST_W] == '0);
    end
    if (cmd_i.emit) begin
      cx_q   <= avg_x;
      cy_q   <= avg_y;
      obtn_q <= btn_q;
    end
  end

  // Output register: hold the result until the downstream side takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  assign stat_o.div_busy = busy_x | busy_y;
  assign stat_o.out_free = ~ovalid_q | out_ready_i;
  assign out_valid_o     = ovalid_q;
  assign out_data_o      = {7'b0, obtn_q, cy_q, cx_q};

endmodule

[hw/rtl/ccs_ctrl.sv]
// Controller: sequences the mapping steps, the divide and the ring update.
module ccs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ccs_pkg::stat_t stat_i,
  output ccs_pkg::cmd_t  cmd_o
);
  import ccs_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_MUL3;
      end
      ST_MUL3: begin
        cmd_o.mul3 = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_START;
      end
      ST_START: begin
        cmd_o.start = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        if (!stat_i.div_busy) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        // Hold until the output register is free.
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/camera_to_screen_cursor_smoother.sv]
// Top level of the camera-to-screen cursor smoother.
//
//  channel   | direction | contents
//  ----------+-----------+--------------------------------------------------
//  s_axis    | in        | tracked point and gesture, one request per point
//  m_axis    | out       | smoothed cursor and button state, one per request
//  cfg       | in        | register writes, index and data, no read-back
//
// Each request is finished before the next is accepted; the bit-serial divider
// (one quotient bit per cycle over a 33-bit numerator magnitude) takes most of that time.
// Reset clears the history valid flags, the running sums and the write slot, and
// loads the register defaults; no clearing pass is needed.
// A new request is accepted while the previous result still waits on m_axis;
// the controller stalls before emitting only while that result is untaken.
module camera_to_screen_cursor_smoother (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [11:0] pos_x, [23:12] pos_y, [31:24] gesture_id
  input  logic [ccs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] cursor_x, [31:16] cursor_y, [32] button_down, [39:33] zero
  output logic [ccs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_we_i,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ccs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ccs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ccs_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
